// ----- hw/rtl/msp_pkg.sv -----
// msp_pkg: shared constants and types of the MSP v1/v2 frame parser.
// Standalone; imported by msp_front, msp_desc_fifo, msp_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

	// payload store size per frame and derived widths
	localparam int PAYLOAD_CAPACITY = 64;
	localparam int PTR_W            = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
	localparam int LEN_W            = $clog2(PAYLOAD_CAPACITY + 1);
	localparam int NUM_BANKS        = 2;
	localparam int BANK_W           = $clog2(NUM_BANKS);
	localparam int MEM_AW           = BANK_W + PTR_W;
	localparam int DESC_DEPTH       = NUM_BANKS;
	localparam int DESC_PTR_W       = $clog2(DESC_DEPTH);
	localparam int CMD_W            = 16;
	localparam int CNT_W            = $clog2(NUM_BANKS + 1);

	// header characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_BANG   = 8'h21;

	localparam logic [7:0] CRC_POLY  = 8'hD5;

	// payload store write port
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	// accepted frame, handed from parser to emitter
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [LEN_W-1:0]  len;
		logic              ver;
		logic              dir;
		logic [BANK_W-1:0] bank;
	} desc_t;

	// one result item
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [LEN_W-1:0] len;
		logic             ver;
		logic             dir;
		logic             has_data;
		logic [PTR_W-1:0] pos;
		logic             last;
	} result_meta_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msp_front.sv -----
// msp_front: byte-level frame recognizer, writes payload into the store and
// queues a descriptor per frame whose checksum matches. Depends on msp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msp_front import msp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] rx_byte,
	output logic            full,
	output mem_wr_t         mem_wr,
	output logic            desc_push,
	output desc_t           desc,
	input  wire logic       frame_release
);

	typedef enum logic [14:0] {
		ST_IDLE      = 15'h0001,
		ST_DOLLAR    = 15'h0002,
		ST_M_DIR     = 15'h0004,
		ST_X_DIR     = 15'h0008,
		ST_V1_SIZE   = 15'h0010,
		ST_V1_CMD    = 15'h0020,
		ST_V1_DATA   = 15'h0040,
		ST_V1_CHECK  = 15'h0080,
		ST_V2_FLAG   = 15'h0100,
		ST_V2_CMD_LO = 15'h0200,
		ST_V2_CMD_HI = 15'h0400,
		ST_V2_LEN_LO = 15'h0800,
		ST_V2_LEN_HI = 15'h1000,
		ST_V2_DATA   = 15'h2000,
		ST_V2_CHECK  = 15'h4000
	} state_t;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

	state_t              state_q;
	logic                ver_q;
	logic                dir_q;
	logic [7:0]          chk_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [7:0]          len_lo_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [BANK_W-1:0]   bank_q;
	logic [CNT_W-1:0]    held_q;

	logic                acc;
	logic                commit;
	logic [LEN_W-1:0]    cnt_nxt;
	logic                in_data;

	assign full    = (held_q == CNT_W'(NUM_BANKS));
	assign acc     = push && !full;
	assign cnt_nxt = cnt_q + LEN_W'(1);
	assign in_data = (state_q == ST_V1_DATA) || (state_q == ST_V2_DATA);
	assign commit  = acc && ((state_q == ST_V1_CHECK) || (state_q == ST_V2_CHECK))
		&& (chk_q == rx_byte);

	assign mem_wr.en   = acc && in_data;
	assign mem_wr.addr = {bank_q, cnt_q[PTR_W-1:0]};
	assign mem_wr.data = rx_byte;

	assign desc_push = commit;
	assign desc.cmd  = cmd_q;
	assign desc.len  = len_q;
	assign desc.ver  = ver_q;
	assign desc.dir  = dir_q;
	assign desc.bank = bank_q;

	// count banks owned by frames not yet fully read out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			bank_q <= '0;
		end else begin
			if (commit && !frame_release) held_q <= held_q + CNT_W'(1);
			else if (!commit && frame_release) held_q <= held_q - CNT_W'(1);
			if (commit) bank_q <= (bank_q == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_q + BANK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ver_q    <= 1'b0;
			dir_q    <= 1'b0;
			chk_q    <= '0;
			cmd_q    <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
		end else if (acc) begin
			case (state_q)
				ST_IDLE: begin
					if (rx_byte == CH_DOLLAR) state_q <= ST_DOLLAR;
				end
				ST_DOLLAR: begin
					if (rx_byte == CH_M) begin
						ver_q   <= 1'b0;
						state_q <= ST_M_DIR;
					end else if (rx_byte == CH_X) begin
						ver_q   <= 1'b1;
						state_q <= ST_X_DIR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_M_DIR, ST_X_DIR: begin
					if (rx_byte == CH_LT || rx_byte == CH_BANG) begin
						dir_q <= (rx_byte == CH_BANG);
						if (state_q == ST_X_DIR) begin
							chk_q   <= '0;
							state_q <= ST_V2_FLAG;
						end else begin
							state_q <= ST_V1_SIZE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_V1_SIZE: begin
					if (rx_byte > 8'(PAYLOAD_CAPACITY)) begin
						state_q <= ST_IDLE;
					end else begin
						len_q   <= rx_byte[LEN_W-1:0];
						chk_q   <= rx_byte;
						state_q <= ST_V1_CMD;
					end
				end
				ST_V1_CMD: begin
					cmd_q   <= {8'h00, rx_byte};
					chk_q   <= chk_q ^ rx_byte;
					cnt_q   <= '0;
					state_q <= (len_q != '0) ? ST_V1_DATA : ST_V1_CHECK;
				end
				ST_V1_DATA: begin
					chk_q <= chk_q ^ rx_byte;
					cnt_q <= cnt_nxt;
					if (cnt_nxt >= len_q) state_q <= ST_V1_CHECK;
				end
				ST_V1_CHECK, ST_V2_CHECK: begin
					state_q <= ST_IDLE;
				end
				ST_V2_FLAG: begin
					chk_q   <= crc_step(chk_q, rx_byte);
					state_q <= ST_V2_CMD_LO;
				end
				ST_V2_CMD_LO: begin
					cmd_q   <= {8'h00, rx_byte};
					chk_q   <= crc_step(chk_q, rx_byte);
					state_q <= ST_V2_CMD_HI;
				end
				ST_V2_CMD_HI: begin
					cmd_q[15:8] <= rx_byte;
					chk_q       <= crc_step(chk_q, rx_byte);
					state_q     <= ST_V2_LEN_LO;
				end
				ST_V2_LEN_LO: begin
					len_lo_q <= rx_byte;
					chk_q    <= crc_step(chk_q, rx_byte);
					state_q  <= ST_V2_LEN_HI;
				end
				ST_V2_LEN_HI: begin
					chk_q <= crc_step(chk_q, rx_byte);
					cnt_q <= '0;
					// drop frames larger than the store
					if (rx_byte != 8'h00 || len_lo_q > 8'(PAYLOAD_CAPACITY)) begin
						state_q <= ST_IDLE;
					end else begin
						len_q   <= len_lo_q[LEN_W-1:0];
						state_q <= (len_lo_q != 8'h00) ? ST_V2_DATA : ST_V2_CHECK;
					end
				end
				ST_V2_DATA: begin
					chk_q <= crc_step(chk_q, rx_byte);
					cnt_q <= cnt_nxt;
					if (cnt_nxt >= len_q) state_q <= ST_V2_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/msp_desc_fifo.sv -----
// msp_desc_fifo: short queue of accepted-frame descriptors between parser
// and emitter. Depends on msp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msp_desc_fifo import msp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  desc_t     wr_desc,
	input  wire logic rd_en,
	output desc_t     rd_desc,
	output logic      empty
);

	desc_t                entry_q [DESC_DEPTH];
	logic [DESC_PTR_W-1:0] wr_ptr_q;
	logic [DESC_PTR_W-1:0] rd_ptr_q;
	logic [DESC_PTR_W:0]   count_q;

	assign empty   = (count_q == '0);
	assign rd_desc = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) entry_q[wr_ptr_q] <= wr_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0
					: wr_ptr_q + DESC_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0
					: rd_ptr_q + DESC_PTR_W'(1);
			end
			if (wr_en && !rd_en) count_q <= count_q + (DESC_PTR_W + 1)'(1);
			else if (!wr_en && rd_en) count_q <= count_q - (DESC_PTR_W + 1)'(1);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/msp_back.sv -----
// msp_back: payload store and result emitter; walks each queued frame and streams one
// result per payload byte (one if empty) via an output register. Depends on msp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msp_back import msp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  mem_wr_t    mem_wr,
	input  wire logic  desc_empty,
	input  desc_t      desc,
	output logic       desc_pop,
	output logic       frame_release,
	input  wire logic  pop,
	output logic       empty,
	output result_meta_t res,
	output logic [7:0] res_data
);

	logic [7:0]       mem [NUM_BANKS * PAYLOAD_CAPACITY];

	logic             active_q;
	desc_t            cur_q;
	logic [LEN_W-1:0] k_q;

	logic             valid_s1;
	result_meta_t     meta_s1;
	logic [7:0]       data_s1;

	logic             out_valid_q;
	result_meta_t     out_q;
	logic [7:0]       out_data_q;

	logic             pop_ok;
	logic             s1_adv;
	logic             issue;
	logic             last_issue;

	assign pop_ok     = pop && out_valid_q;
	assign s1_adv     = valid_s1 && (!out_valid_q || pop_ok);
	assign issue      = active_q && (!valid_s1 || s1_adv);
	assign last_issue = (cur_q.len == '0) || ((k_q + LEN_W'(1)) == cur_q.len);
	assign desc_pop   = !active_q && !desc_empty;

	assign empty         = !out_valid_q;
	assign res           = out_q;
	assign res_data      = out_data_q;
	assign frame_release = pop_ok && out_q.last;

	// payload store: parser writes, emitter reads; read data held while stalled
	always_ff @(posedge clk) begin
		if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
		if (issue) data_s1 <= mem[{cur_q.bank, k_q[PTR_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (desc_pop) begin
			active_q <= 1'b1;
			k_q      <= '0;
		end else if (issue) begin
			k_q <= k_q + LEN_W'(1);
			if (last_issue) active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) cur_q <= desc;
		if (issue) begin
			meta_s1.cmd      <= cur_q.cmd;
			meta_s1.len      <= cur_q.len;
			meta_s1.ver      <= cur_q.ver;
			meta_s1.dir      <= cur_q.dir;
			meta_s1.has_data <= (cur_q.len != '0);
			meta_s1.pos      <= k_q[PTR_W-1:0];
			meta_s1.last     <= last_issue;
		end
		if (s1_adv) begin
			out_q      <= meta_s1;
			out_data_q <= meta_s1.has_data ? data_s1 : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (pop_ok) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/msp_frame_parser_top.sv -----
// msp_frame_parser_top: MSP v1/v2 request frame parser, top level.
// Depends on msp_pkg, msp_front, msp_desc_fifo and msp_back.
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ----------------------------------------
// rx        in         push / full            rx_byte
// result    out        pop / empty            command_code, frame_length,
//                                             is_version_two, error_direction, has_data,
//                                             data_byte, data_position, last_of_frame
//
// Rates: one received byte per cycle while full is low; results are read out of the
// payload store through its single read port, one payload byte after another.
// Reset: arst_n clears the parser, queue and output control at once; the payload
// store needs no clearing since every byte read out was written in its own frame.
// Stalls: the store holds two frames; full rises while both hold frames not yet fully read out.
`timescale 1ns / 1ps
`default_nettype none

module msp_frame_parser_top import msp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                pop,
	output logic                     empty,
	output logic [CMD_W-1:0]         command_code,
	output logic [LEN_W-1:0]         frame_length,
	output logic                     is_version_two,
	output logic                     error_direction,
	output logic                     has_data,
	output logic [7:0]               data_byte,
	output logic [PTR_W-1:0]         data_position,
	output logic                     last_of_frame
);

	mem_wr_t      mem_wr;
	logic         desc_push;
	desc_t        desc_in;
	logic         desc_pop;
	desc_t        desc_out;
	logic         desc_empty;
	logic         frame_release;
	result_meta_t res;

	// front: parse bytes, fill the payload bank, queue good frames
	msp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.rx_byte       (rx_byte),
		.full          (full),
		.mem_wr        (mem_wr),
		.desc_push     (desc_push),
		.desc          (desc_in),
		.frame_release (frame_release)
	);

	// decouple parser from emitter
	msp_desc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_push),
		.wr_desc (desc_in),
		.rd_en   (desc_pop),
		.rd_desc (desc_out),
		.empty   (desc_empty)
	);

	// back: read out each frame as a run of result transactions
	msp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mem_wr        (mem_wr),
		.desc_empty    (desc_empty),
		.desc          (desc_out),
		.desc_pop      (desc_pop),
		.frame_release (frame_release),
		.pop           (pop),
		.empty         (empty),
		.res           (res),
		.res_data      (data_byte)
	);

	assign command_code    = res.cmd;
	assign frame_length    = res.len;
	assign is_version_two  = res.ver;
	assign error_direction = res.dir;
	assign has_data        = res.has_data;
	assign data_position   = res.pos;
	assign last_of_frame   = res.last;

endmodule

`default_nettype wire

// ----- verif/msp_frame_check_pkg.sv -----
`timescale 1ns / 1ps
// msp_frame_check_pkg: result type, CRC helper and frame scoreboard for the
// MSP v1/v2 frame parser testbench. Depends on msp_pkg.

package msp_frame_check_pkg;

	import msp_pkg::*;

	typedef enum logic [3:0] {
		PS_IDLE,
		PS_DOLLAR,
		PS_V1_DIR,
		PS_V2_DIR,
		PS_V1_SIZE,
		PS_V1_CMD,
		PS_V1_DATA,
		PS_V1_CHECK,
		PS_V2_FLAG,
		PS_V2_CMD_LO,
		PS_V2_CMD_HI,
		PS_V2_LEN_LO,
		PS_V2_LEN_HI,
		PS_V2_DATA,
		PS_V2_CHECK
	} rx_phase_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [LEN_W-1:0] len;
		logic             ver;
		logic             dir;
		logic             has_data;
		logic [7:0]       data;
		logic [PTR_W-1:0] pos;
		logic             last;
	} frame_result_t;

	localparam int REPORT_LIMIT = 10;

	// one byte of CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_d5_update(logic [7:0] crc, logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++)
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		return v;
	endfunction

	class frame_scoreboard;
		rx_phase_t     phase;
		logic          ver2;
		logic          bang;
		logic [7:0]    chk;
		logic [15:0]   cmd;
		logic [15:0]   decl_len;
		int            count;
		logic [7:0]    payload[PAYLOAD_CAPACITY];
		frame_result_t expected_q[$];
		int            mismatches;

		function new();
			phase      = PS_IDLE;
			ver2       = 1'b0;
			bang       = 1'b0;
			chk        = '0;
			cmd        = '0;
			decl_len   = '0;
			count      = 0;
			mismatches = 0;
		endfunction

		function string fmt(frame_result_t r);
			return $sformatf("cmd=%h len=%0d ver=%b dir=%b has_data=%b data=%h pos=%0d last=%b",
				r.cmd, r.len, r.ver, r.dir, r.has_data, r.data, r.pos, r.last);
		endfunction

		// advance the parser image by one accepted byte; queue results on a good check
		function void note_rx_byte(logic [7:0] b);
			frame_result_t r;
			int n;
			case (phase)
				PS_IDLE: begin
					if (b == CH_DOLLAR)
						phase = PS_DOLLAR;
				end
				PS_DOLLAR: begin
					if (b == CH_M) begin
						ver2  = 1'b0;
						phase = PS_V1_DIR;
					end else if (b == CH_X) begin
						ver2  = 1'b1;
						phase = PS_V2_DIR;
					end else
						phase = PS_IDLE;
				end
				PS_V1_DIR, PS_V2_DIR: begin
					if (b == CH_LT || b == CH_BANG) begin
						bang = (b == CH_BANG);
						if (phase == PS_V2_DIR) begin
							chk   = '0;
							phase = PS_V2_FLAG;
						end else
							phase = PS_V1_SIZE;
					end else
						phase = PS_IDLE;
				end
				PS_V1_SIZE: begin
					if (b > PAYLOAD_CAPACITY)
						phase = PS_IDLE;
					else begin
						decl_len = {8'h00, b};
						chk      = b;
						phase    = PS_V1_CMD;
					end
				end
				PS_V1_CMD: begin
					cmd   = {8'h00, b};
					chk   = chk ^ b;
					count = 0;
					phase = (decl_len != 0) ? PS_V1_DATA : PS_V1_CHECK;
				end
				PS_V1_DATA, PS_V2_DATA: begin
					payload[count] = b;
					count++;
					chk = (phase == PS_V2_DATA) ? crc8_d5_update(chk, b) : (chk ^ b);
					if (count >= decl_len)
						phase = (phase == PS_V2_DATA) ? PS_V2_CHECK : PS_V1_CHECK;
				end
				PS_V1_CHECK, PS_V2_CHECK: begin
					if (chk == b) begin
						n = (decl_len == 0) ? 1 : int'(decl_len);
						for (int k = 0; k < n; k++) begin
							r.cmd      = cmd;
							r.len      = decl_len[LEN_W-1:0];
							r.ver      = ver2;
							r.dir      = bang;
							r.has_data = (decl_len != 0);
							r.data     = r.has_data ? payload[k] : 8'h00;
							r.pos      = r.has_data ? k[PTR_W-1:0] : '0;
							r.last     = (k == n - 1);
							expected_q.push_back(r);
						end
					end
					phase = PS_IDLE;
				end
				PS_V2_FLAG: begin
					chk   = crc8_d5_update(chk, b);
					phase = PS_V2_CMD_LO;
				end
				PS_V2_CMD_LO: begin
					cmd   = {8'h00, b};
					chk   = crc8_d5_update(chk, b);
					phase = PS_V2_CMD_HI;
				end
				PS_V2_CMD_HI: begin
					cmd[15:8] = b;
					chk       = crc8_d5_update(chk, b);
					phase     = PS_V2_LEN_LO;
				end
				PS_V2_LEN_LO: begin
					decl_len = {8'h00, b};
					chk      = crc8_d5_update(chk, b);
					phase    = PS_V2_LEN_HI;
				end
				PS_V2_LEN_HI: begin
					decl_len[15:8] = b;
					chk            = crc8_d5_update(chk, b);
					count          = 0;
					if (decl_len > PAYLOAD_CAPACITY)
						phase = PS_IDLE;
					else
						phase = (decl_len != 0) ? PS_V2_DATA : PS_V2_CHECK;
				end
				default: phase = PS_IDLE;
			endcase
		endfunction

		// compare one accepted result against the oldest expectation
		function void check_result(frame_result_t got);
			frame_result_t want;
			logic bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: %s", fmt(got));
				return;
			end
			want = expected_q.pop_front();
			bad = (got.cmd !== want.cmd) || (got.len !== want.len) ||
				(got.ver !== want.ver) || (got.dir !== want.dir) ||
				(got.has_data !== want.has_data) || (got.data !== want.data) ||
				(got.pos !== want.pos) || (got.last !== want.last);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("result mismatch");
					$display("  expected: %s", fmt(want));
					$display("  actual:   %s", fmt(got));
				end
			end
		endfunction
	endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: testbench for msp_frame_parser_top, directed then random byte streams.
// Depends on msp_pkg, msp_frame_check_pkg and the parser RTL.

module tb_top;

	import msp_pkg::*;
	import msp_frame_check_pkg::*;

	// stimulus volume and run bounds
	localparam int RANDOM_ITEMS = 470;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 2000000;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 push    = 1'b0;
	logic [7:0]           rx_byte = 8'h00;
	logic                 pop     = 1'b0;
	logic                 full;
	logic                 empty;
	logic [CMD_W-1:0]     command_code;
	logic [LEN_W-1:0]     frame_length;
	logic                 is_version_two;
	logic                 error_direction;
	logic                 has_data;
	logic [7:0]           data_byte;
	logic [PTR_W-1:0]     data_position;
	logic                 last_of_frame;

	frame_scoreboard sb;
	int cycle_count   = 0;
	int counted_bytes = 0;

	// per-side idle pattern: each run of transactions has random gaps or none
	int rx_left  = 0;
	bit rx_calm  = 1'b0;
	int res_left = 0;
	bit res_calm = 1'b0;

	msp_frame_parser_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.rx_byte         (rx_byte),
		.pop             (pop),
		.empty           (empty),
		.command_code    (command_code),
		.frame_length    (frame_length),
		.is_version_two  (is_version_two),
		.error_direction (error_direction),
		.has_data        (has_data),
		.data_byte       (data_byte),
		.data_position   (data_position),
		.last_of_frame   (last_of_frame)
	);

	always #5 clk = ~clk;

	// hard stop: well above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[msp_frame_parser_top] ERROR");
			$finish;
		end
	end

	// Draw the wait before the next transaction on one side. A run of 20 to 60
	// transactions either has a random wait before each or none at all.
	function automatic int draw_wait(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(20, 60);
			calm = ($urandom_range(0, 2) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// Push one byte. Hold push high across back-to-back transactions; drop it
	// only when a gap follows, so push gets one update per edge.
	task automatic send_byte(input logic [7:0] value, input bit counts = 1'b1);
		int gap;
		gap = draw_wait(rx_left, rx_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= value;
		// the transaction completes at the first edge that sees full low
		do @(posedge clk); while (full);
		sb.note_rx_byte(value);
		if (counts)
			counted_bytes++;
	endtask

	// Build a frame of either version and push it. A size above the store
	// capacity ends right after the size bytes, since the parser aborts there.
	// corrupt flips the check byte; cut >= 0 truncates the frame to cut bytes.
	task automatic send_frame(input bit v2, input bit bang, input logic [15:0] cmd,
			input logic [15:0] len, input bit corrupt, input int cut);
		logic [7:0] q[$];
		logic [7:0] chk;
		int stop;
		q.push_back(CH_DOLLAR);
		q.push_back(v2 ? CH_X : CH_M);
		q.push_back(bang ? CH_BANG : CH_LT);
		if (v2) begin
			q.push_back(8'($urandom_range(0, 255)));
			q.push_back(cmd[7:0]);
			q.push_back(cmd[15:8]);
			q.push_back(len[7:0]);
			q.push_back(len[15:8]);
		end else begin
			q.push_back(len[7:0]);
			if (len <= PAYLOAD_CAPACITY)
				q.push_back(cmd[7:0]);
		end
		if (len <= PAYLOAD_CAPACITY) begin
			repeat (len) q.push_back(8'($urandom_range(0, 255)));
			// XOR from size in v1, CRC from flag in v2; both start after the direction
			chk = 8'h00;
			for (int i = 3; i < q.size(); i++)
				chk = v2 ? crc8_d5_update(chk, q[i]) : (chk ^ q[i]);
			if (corrupt)
				chk = chk ^ 8'($urandom_range(1, 255));
			q.push_back(chk);
		end
		stop = (cut < 0 || cut > q.size()) ? q.size() : cut;
		for (int i = 0; i < stop; i++)
			send_byte(q[i]);
	endtask

	// One random transaction group: mostly well-formed frames with random
	// content, the rest bad checks, oversize, bad headers, truncation, noise.
	task automatic random_traffic();
		int kind;
		int pick;
		bit v2;
		bit bang;
		logic [15:0] cmd;
		logic [15:0] len;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 19);
		v2   = 1'($urandom_range(0, 1));
		bang = 1'($urandom_range(0, 1));
		cmd  = v2 ? 16'($urandom_range(0, 16'hFFFF)) : 16'($urandom_range(0, 255));
		// keep most frames short; a few fill the store
		if (pick == 0)
			len = PAYLOAD_CAPACITY;
		else if (pick == 1)
			len = 0;
		else if (pick < 4)
			len = 16'($urandom_range(9, PAYLOAD_CAPACITY - 1));
		else
			len = 16'($urandom_range(1, 8));
		if (kind < 68)
			send_frame(v2, bang, cmd, len, 1'b0, -1);
		else if (kind < 78)
			send_frame(v2, bang, cmd, len, 1'b1, -1);
		else if (kind < 84) begin
			if (!v2 || $urandom_range(0, 1))
				len = 16'($urandom_range(PAYLOAD_CAPACITY + 1, 255));
			else
				len = 16'($urandom_range(256, 16'hFFFF));
			send_frame(v2, bang, cmd, len, 1'b0, -1);
		end else if (kind < 89) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_M || b == CH_X);
			send_byte(CH_DOLLAR);
			send_byte(b);
		end else if (kind < 93) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_LT || b == CH_BANG);
			send_byte(CH_DOLLAR);
			send_byte(v2 ? CH_X : CH_M);
			send_byte(b);
		end else if (kind < 97)
			send_frame(v2, bang, cmd, len, 1'b0, $urandom_range(1, 5 + len));
		else
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Result side: pop with random gaps and check every transaction in order.
	initial begin : result_side
		int gap;
		frame_result_t got;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_wait(res_left, res_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.cmd      = command_code;
			got.len      = frame_length;
			got.ver      = is_version_two;
			got.dir      = error_direction;
			got.has_data = has_data;
			got.data     = data_byte;
			got.pos      = data_position;
			got.last     = last_of_frame;
			sb.check_result(got);
		end
	end

	// Main sequence: reset, directed cases, random traffic, drain, verdict.
	initial begin : stimulus
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty v1 request, zero command
		send_frame(1'b0, 1'b0, 16'h0000, 16'd0, 1'b0, -1);
		// empty v2 error frame, all-ones command
		send_frame(1'b1, 1'b1, 16'hFFFF, 16'd0, 1'b0, -1);
		// bad byte after the dollar drops back to idle
		send_byte(CH_DOLLAR);
		send_byte(8'h51);
		// bad direction byte
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte(8'h3F);
		// v1 size one above capacity aborts after the size
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte(CH_LT);
		send_byte(8'(PAYLOAD_CAPACITY + 1));
		// second dollar is the bad header byte; the frame after it is not seen
		send_byte(CH_DOLLAR);
		send_frame(1'b0, 1'b1, 16'h00FF, 16'd0, 1'b0, -1);

		counted_bytes = 0;
		while (counted_bytes < RANDOM_ITEMS)
			random_traffic();
		push <= 1'b0;

		// drain: wait for every expected result, then watch for strays
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("[msp_frame_parser_top] OK");
		else
			$display("[msp_frame_parser_top] ERROR");
		$finish;
	end

endmodule
